@@ sv/raw_packet_pixel_decoder_assert.svh @@
// -----------------------------------------------------------------------------
// raw_packet_pixel_decoder_assert.svh
// Assertion macros shared by the checkers of the raw packet pixel decoder.
// -----------------------------------------------------------------------------
`ifndef RAW_PACKET_PIXEL_DECODER_ASSERT_SVH
`define RAW_PACKET_PIXEL_DECODER_ASSERT_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define RPPD_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("raw packet pixel decoder assertion failed");

// Implication whose consequent is checked in the cycle after its antecedent.
`define RPPD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("raw packet pixel decoder assertion failed");

`endif

@@ sv/rppd_pkg.sv @@
// -----------------------------------------------------------------------------
// rppd_pkg
// Constants, codes and shared types of the raw packet pixel decoder.
// -----------------------------------------------------------------------------
package rppd_pkg;

   localparam int BLOCK_BYTES       = 16384;
   localparam int ADDR_W            = $clog2(BLOCK_BYTES);
   localparam int PIXELS_PER_PACKET = 14;
   localparam int PIX_IDX_W         = $clog2(PIXELS_PER_PACKET);
   localparam int BIT_POS_W         = 17;
   localparam int SPLIT_W           = 15;
   localparam int PIXEL_W           = 16;
   localparam int PRED_W            = 18;
   localparam int SHIFT_W           = 3;

   // Opcodes of an input item.
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_DECODE = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_BAD = 1'd1;

   localparam logic [ADDR_W-1:0] ADDR_XOR   = 14'h3ff0;
   localparam logic [7:0]        DELTA_BIAS = 8'h80;
   localparam logic [SHIFT_W-1:0] SHIFT_FULL = 3'd4;
   localparam logic [PIX_IDX_W-1:0] LAST_ABS_PIX = 4'd11;
   localparam logic [PIX_IDX_W-1:0] LAST_PIX = PIX_IDX_W'(PIXELS_PER_PACKET - 1);

   typedef struct packed {
      logic start_block;
      logic load;
      logic decode;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_req_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr_lo;
      logic [ADDR_W-1:0] addr_hi;
   } rd_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               zero_flag;
      logic               last_in_packet;
   } pixel_type;

endpackage

@@ sv/rppd_ram.sv @@
// -----------------------------------------------------------------------------
// rppd_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// -----------------------------------------------------------------------------
module rppd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ sv/rppd_loader.sv @@
// -----------------------------------------------------------------------------
// rppd_loader
// Write position and rotated write address of the block memory.
// -----------------------------------------------------------------------------
module rppd_loader
   import rppd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [7:0]         byte_value,
   input  logic [SPLIT_W-1:0] split_offset,
   output wr_req_type         wr_req
);

   logic [ADDR_W-1:0] wp_ff;
   logic [ADDR_W-1:0] wp_in;
   logic [ADDR_W-1:0] split_eff;

   // An offset of a whole block or more means no rotation.
   assign split_eff = split_offset[SPLIT_W-1] ? '0 : split_offset[ADDR_W-1:0];

   always_comb begin
      wp_in = wp_ff;
      if (cmd.start_block) begin
         wp_in = '0;
      end else if (cmd.load) begin
         wp_in = wp_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
      end
   end

   assign wr_req.en   = cmd.load;
   assign wr_req.addr = wp_ff - split_eff;
   assign wr_req.data = byte_value;

endmodule

@@ sv/rppd_unpack.sv @@
// -----------------------------------------------------------------------------
// rppd_unpack
// Packet sequencer: backward bit reads from the block memory, the two-colour
// predictor and the output register for decoded pixels.
// -----------------------------------------------------------------------------
module rppd_unpack
   import rppd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic       zero_bad_en,
   output rd_req_type rd_req,
   input  logic [7:0] rd_data_lo,
   input  logic [7:0] rd_data_hi,
   output logic       busy,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output pixel_type  rsp_item
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SH_RD  = 3'd1;
   localparam logic [2:0] ST_SH_DAT = 3'd2;
   localparam logic [2:0] ST_BY_RD  = 3'd3;
   localparam logic [2:0] ST_BY_DAT = 3'd4;
   localparam logic [2:0] ST_LO_RD  = 3'd5;
   localparam logic [2:0] ST_LO_DAT = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [BIT_POS_W-1:0] bp_ff, bp_in;
   logic [PIX_IDX_W-1:0] pix_ff, pix_in;
   logic [SHIFT_W-1:0]   sh_ff, sh_in;
   logic [PRED_W-1:0]    pred_ff [2];
   logic [PRED_W-1:0]    pred_in [2];
   logic [1:0]           nz_ff, nz_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 hi_zero_ff, hi_zero_in;
   logic                 out_vld_ff, out_vld_in;
   pixel_type            out_ff, out_in;

   logic                 chan;
   logic [PRED_W-1:0]    pred_cur;
   logic [15:0]          word;
   logic [15:0]          bits;
   logic [BIT_POS_W-1:0] count;
   logic                 issue;
   logic [ADDR_W-1:0]    rd_addr;
   logic [PRED_W-1:0]    delta_tmp;
   logic [PRED_W-1:0]    delta_mask;
   logic [PRED_W-1:0]    delta_res;
   logic [PIX_IDX_W-1:0] pix_next;

   function automatic logic [2:0] pixel_first_state(input logic [PIX_IDX_W-1:0] pix);
      logic [2:0] st;
      st = ST_BY_RD;
      // Pixels two, five, eight and eleven refresh the shift first.
      if (pix inside {4'd2, 4'd5, 4'd8, 4'd11}) begin
         st = ST_SH_RD;
      end
      return st;
   endfunction

   assign chan     = pix_ff[0];
   assign pred_cur = pred_ff[chan];
   assign pix_next = pix_ff + PIX_IDX_W'(1);

   // The high byte of a read that runs past the last address counts as zero.
   assign word = {(hi_zero_ff ? 8'h00 : rd_data_hi), rd_data_lo};
   assign bits = word >> bp_ff[2:0];

   always_comb begin
      delta_tmp  = pred_cur - (PRED_W'(DELTA_BIAS) << sh_ff);
      delta_mask = (PRED_W'(1) << sh_ff) - PRED_W'(1);
      if (delta_tmp[PRED_W-1] || (sh_ff == SHIFT_FULL)) begin
         delta_tmp = delta_tmp & delta_mask;
      end
      delta_res = delta_tmp + (PRED_W'(bits[7:0]) << sh_ff);
   end

   always_comb begin
      case (state_ff)
         ST_SH_RD: begin
            issue = 1'b1;
            count = BIT_POS_W'(2);
         end
         ST_BY_RD: begin
            issue = 1'b1;
            count = BIT_POS_W'(8);
         end
         ST_LO_RD: begin
            issue = 1'b1;
            count = BIT_POS_W'(4);
         end
         default: begin
            issue = 1'b0;
            count = '0;
         end
      endcase
   end

   assign rd_addr        = bp_in[BIT_POS_W-1:3] ^ ADDR_XOR;
   assign rd_req.en      = issue;
   assign rd_req.addr_lo = rd_addr;
   assign rd_req.addr_hi = rd_addr + ADDR_W'(1);

   always_comb begin
      state_in   = state_ff;
      bp_in      = bp_ff;
      pix_in     = pix_ff;
      sh_in      = sh_ff;
      pred_in    = pred_ff;
      nz_in      = nz_ff;
      byte_in    = byte_ff;
      hi_zero_in = hi_zero_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff;

      if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end

      if (issue) begin
         bp_in      = bp_ff - count;
         hi_zero_in = (rd_addr == '1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_block) begin
               bp_in = '0;
            end
            if (cmd.decode) begin
               pix_in   = '0;
               sh_in    = '0;
               nz_in    = '0;
               pred_in  = '{default: '0};
               state_in = pixel_first_state('0);
            end
         end
         ST_SH_RD: state_in = ST_SH_DAT;
         ST_SH_DAT: begin
            case (bits[1:0])
               2'd0:    sh_in = 3'd0;
               2'd1:    sh_in = 3'd1;
               2'd2:    sh_in = 3'd2;
               default: sh_in = SHIFT_FULL;
            endcase
            state_in = ST_BY_RD;
         end
         ST_BY_RD: state_in = ST_BY_DAT;
         ST_BY_DAT: begin
            state_in = ST_OUT;
            if (nz_ff[chan]) begin
               if (bits[7:0] != 8'h00) begin
                  pred_in[chan] = delta_res;
               end
            end else begin
               nz_in[chan] = (bits[7:0] != 8'h00);
               byte_in     = bits[7:0];
               if ((bits[7:0] != 8'h00) || (pix_ff > LAST_ABS_PIX)) begin
                  state_in = ST_LO_RD;
               end
            end
         end
         ST_LO_RD: state_in = ST_LO_DAT;
         ST_LO_DAT: begin
            pred_in[chan] = PRED_W'({byte_ff, bits[3:0]});
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!out_vld_ff || !rsp_stall) begin
               out_in.pixel_value    = pred_cur[PIXEL_W-1:0];
               out_in.zero_flag      = zero_bad_en && (pred_cur == '0);
               out_in.last_in_packet = (pix_ff == LAST_PIX);
               out_vld_in            = 1'b1;
               if (pix_ff == LAST_PIX) begin
                  state_in = ST_IDLE;
               end else begin
                  pix_in   = pix_next;
                  state_in = pixel_first_state(pix_next);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bp_ff      <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bp_ff      <= bp_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff     <= pix_in;
      sh_ff      <= sh_in;
      pred_ff    <= pred_in;
      nz_ff      <= nz_in;
      byte_ff    <= byte_in;
      hi_zero_ff <= hi_zero_in;
      out_ff     <= out_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_ff;

endmodule

@@ sv/raw_packet_pixel_decoder.sv @@
// -----------------------------------------------------------------------------
// raw_packet_pixel_decoder
// Loads a 16384-byte block of packed raw data and decodes 14-pixel packets.
// -----------------------------------------------------------------------------
// Start-block and load-byte items never stall the input, so between decodes a
// block streams in at one byte per clock; loaded bytes land in the block memory
// rotated by split_offset. A decode item yields fourteen pixel items and holds
// the input stalled while it runs: every bit read is one access to the block
// memory (an address state, then a state that takes the registered data), a
// pixel needs one or two such reads plus one more before pixels two, five,
// eight and eleven, and an output state to move it into the output register.
// Each colour makes exactly one four-bit read per packet. The last pixel waits
// in the output register while the next item is already taken. There is no
// clearing pass: the memory must be loaded before the bytes a decode reaches
// are read.
// -----------------------------------------------------------------------------
module raw_packet_pixel_decoder
   import rppd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [7:0]           req_byte_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIXEL_W-1:0]   rsp_pixel_value,
   output logic                 rsp_zero_flag,
   output logic                 rsp_last_in_packet,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SPLIT_W-1:0]   csr_wdata
);

   logic [SPLIT_W-1:0] split_ff;
   logic               zero_bad_ff;
   logic               busy;
   logic               accept;
   cmd_type            cmd;
   wr_req_type         wr_req;
   rd_req_type         rd_req;
   logic [7:0]         rd_data_lo;
   logic [7:0]         rd_data_hi;
   pixel_type          out_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff    <= '0;
         zero_bad_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPLIT:    split_ff    <= csr_wdata;
            CSR_ZERO_BAD: zero_bad_ff <= csr_wdata[0];
            default:      ;
         endcase
      end
   end

   // One item at a time: the memory is never written while a packet is read.
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   always_comb begin
      cmd = '0;
      if (accept) begin
         case (req_opcode)
            OP_START:  cmd.start_block = 1'b1;
            OP_LOAD:   cmd.load        = 1'b1;
            OP_DECODE: cmd.decode      = 1'b1;
            default:   cmd             = '0;
         endcase
      end
   end

   rppd_loader u_loader (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .byte_value   (req_byte_value),
      .split_offset (split_ff),
      .wr_req       (wr_req)
   );

   rppd_ram #(
      .WIDTH (8),
      .DEPTH (BLOCK_BYTES)
   ) u_block_mem (
      .clock     (clock),
      .wr_en     (wr_req.en),
      .wr_addr   (wr_req.addr),
      .wr_data   (wr_req.data),
      .rd_en     (rd_req.en),
      .rd_addr_a (rd_req.addr_lo),
      .rd_addr_b (rd_req.addr_hi),
      .rd_data_a (rd_data_lo),
      .rd_data_b (rd_data_hi)
   );

   rppd_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .zero_bad_en (zero_bad_ff),
      .rd_req      (rd_req),
      .rd_data_lo  (rd_data_lo),
      .rd_data_hi  (rd_data_hi),
      .busy        (busy),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_item    (out_item)
   );

   assign rsp_pixel_value    = out_item.pixel_value;
   assign rsp_zero_flag      = out_item.zero_flag;
   assign rsp_last_in_packet = out_item.last_in_packet;

endmodule

@@ sv/rppd_checker.sv @@
// -----------------------------------------------------------------------------
// rppd_checker
// Port-level checks of the raw packet pixel decoder, bound to the top level.
// -----------------------------------------------------------------------------
`include "raw_packet_pixel_decoder_assert.svh"

module rppd_checker
   import rppd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [1:0]           req_opcode,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [PIXEL_W-1:0]   rsp_pixel_value,
   input logic                 rsp_zero_flag,
   input logic                 rsp_last_in_packet
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // A pixel held by back pressure keeps its value.
   `RPPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_value))

   // A flagged pixel is zero.
   `RPPD_ASSERT_SAME(a_flag_zero, rsp_valid && rsp_zero_flag, rsp_pixel_value == '0)

   // Until the last pixel of a packet is out, no new item is taken.
   `RPPD_ASSERT_SAME(a_packet_busy, rsp_valid && !rsp_last_in_packet, req_stall)

   // A decode occupies the block; start and load items leave it free.
   `RPPD_ASSERT_NEXT(a_decode_busy, req_take && (req_opcode == OP_DECODE), req_stall)
   `RPPD_ASSERT_NEXT(a_load_free, req_take && (req_opcode != OP_DECODE), !req_stall)

endmodule

bind raw_packet_pixel_decoder rppd_checker u_rppd_checker (.*);

@@ test/rppd_decode_check.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rppd_decode_check
// Watches the item, result and register channels of the raw packet pixel
// decoder, keeps its own copy of the block memory and bit position, works out
// the fourteen pixels of every accepted decode item and compares each accepted
// pixel with the oldest one still expected.
// -----------------------------------------------------------------------------
module rppd_decode_check
   import rppd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [7:0]           req_byte_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [PIXEL_W-1:0]   rsp_pixel_value,
   input  logic                 rsp_zero_flag,
   input  logic                 rsp_last_in_packet,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SPLIT_W-1:0]   csr_wdata,
   output int                   fail_count,
   output int                   pixels_pending
);

   localparam int REPORT_LIMIT = 10;

   logic [7:0]           shadow_mem [BLOCK_BYTES];
   logic [ADDR_W-1:0]    load_pos;
   logic [BIT_POS_W-1:0] bit_cursor;
   logic [SPLIT_W-1:0]   split_cfg;
   logic                 zero_bad_cfg;
   pixel_type            expected_pixels [$];

   // Steps the bit position back by count bits and returns the bits found there.
   function automatic logic [7:0] read_bits_backward(input int count);
      logic [ADDR_W-1:0] addr;
      logic [15:0]       word;
      bit_cursor = bit_cursor - BIT_POS_W'(count);
      addr = bit_cursor[BIT_POS_W-1:3] ^ ADDR_XOR;
      word[7:0] = shadow_mem[addr];
      // The byte past the last address reads as zero.
      word[15:8] = (addr == ADDR_W'(BLOCK_BYTES - 1)) ? 8'h00 : shadow_mem[addr + 1'b1];
      word = word >> bit_cursor[2:0];
      return word[7:0] & 8'((1 << count) - 1);
   endfunction

   always @(posedge clock) begin : track
      int         pred [2];
      logic [7:0] seed [2];
      int         shift;
      int         side;
      logic [7:0] step;
      pixel_type  pix;
      pixel_type  want;

      if (reset) begin
         load_pos = '0;
         bit_cursor = '0;
         split_cfg = '0;
         zero_bad_cfg = 1'b0;
         fail_count = 0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: pixel with none expected: value %0h zero %0b last %0b",
                           $time, rsp_pixel_value, rsp_zero_flag, rsp_last_in_packet);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_value !== want.pixel_value ||
                   rsp_zero_flag !== want.zero_flag ||
                   rsp_last_in_packet !== want.last_in_packet) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("%0t: pixel mismatch: expected %0h/%0b/%0b, got %0h/%0b/%0b",
                              $time, want.pixel_value, want.zero_flag,
                              want.last_in_packet, rsp_pixel_value, rsp_zero_flag,
                              rsp_last_in_packet);
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SPLIT:    split_cfg = csr_wdata;
               CSR_ZERO_BAD: zero_bad_cfg = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            case (req_opcode)
               OP_START: begin
                  load_pos = '0;
                  bit_cursor = '0;
               end
               OP_LOAD: begin
                  // An offset at or past the block size leaves the block unrotated.
                  if (split_cfg >= SPLIT_W'(BLOCK_BYTES))
                     shadow_mem[load_pos] = req_byte_value;
                  else
                     shadow_mem[load_pos - split_cfg[ADDR_W-1:0]] = req_byte_value;
                  load_pos = load_pos + 1'b1;
               end
               OP_DECODE: begin
                  pred[0] = 0;
                  pred[1] = 0;
                  seed[0] = 8'h00;
                  seed[1] = 8'h00;
                  shift = 0;
                  for (int p = 0; p < PIXELS_PER_PACKET; p++) begin
                     side = p % 2;
                     if (p % 3 == 2)
                        shift = int'(SHIFT_FULL) >> (3 - int'(read_bits_backward(2)));
                     if (seed[side] != 8'h00) begin
                        step = read_bits_backward(8);
                        if (step != 8'h00) begin
                           pred[side] -= int'(DELTA_BIAS) << shift;
                           if (pred[side] < 0 || shift == int'(SHIFT_FULL))
                              pred[side] &= (1 << shift) - 1;
                           pred[side] += int'(step) << shift;
                        end
                     end else begin
                        // A colour stays at its old value until its first nonzero
                        // byte, except for the last two pixels of the packet.
                        seed[side] = read_bits_backward(8);
                        if (seed[side] != 8'h00 || p > int'(LAST_ABS_PIX))
                           pred[side] = (int'(seed[side]) << 4) |
                                        int'(read_bits_backward(4));
                     end
                     pix.pixel_value = pred[side][PIXEL_W-1:0];
                     pix.zero_flag = zero_bad_cfg && pred[side] == 0;
                     pix.last_in_packet = (p == PIXELS_PER_PACKET - 1);
                     expected_pixels.insert(expected_pixels.size(), pix);
                  end
               end
               default: ;
            endcase
         end
      end
      pixels_pending = expected_pixels.size();
   end

endmodule

@@ test/raw_packet_pixel_decoder_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// raw_packet_pixel_decoder_tb
// Fills the bytes that the first packets after a start can reach, then runs
// short directed packets, random block sequences under several register
// settings with random stalls on both channels, and a final run without
// idling. The pixel checker beside the block does the prediction.
// -----------------------------------------------------------------------------
module raw_packet_pixel_decoder_tb;
   import rppd_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Every packet consumes sixteen bytes, and its top read also touches the next byte.
   localparam int FILL_PACKETS      = 4;
   localparam int FILL_BYTES        = 16 * FILL_PACKETS + 1;
   localparam int RANDOM_PHASES     = 8;
   localparam int PHASE_ITEMS       = 20;
   localparam int FINAL_LOADS       = 16;
   localparam int DRAIN_CYCLES      = 20;
   localparam int TAIL_CYCLES       = 200;
   localparam int CYCLE_LIMIT       = 1000000;
   localparam int SPLIT_MAX         = (1 << SPLIT_W) - 1;
   // Puts the first byte loaded after a start at the address of the first bit read.
   localparam int DIRECTED_SPLIT    = BLOCK_BYTES - 15;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_opcode;
   logic [7:0]           req_byte_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PIXEL_W-1:0]   rsp_pixel_value;
   logic                 rsp_zero_flag;
   logic                 rsp_last_in_packet;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SPLIT_W-1:0]   csr_wdata;
   int                   fail_count;
   int                   pixels_pending;
   int                   items_sent;
   int                   packets_open;
   int                   cycle_count;
   bit                   idling_on = 1'b0;

   raw_packet_pixel_decoder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_byte_value     (req_byte_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_zero_flag      (rsp_zero_flag),
      .rsp_last_in_packet (rsp_last_in_packet),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   rppd_decode_check pixel_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_byte_value     (req_byte_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_zero_flag      (rsp_zero_flag),
      .rsp_last_in_packet (rsp_last_in_packet),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pixels_pending     (pixels_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Result side back pressure in random bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic send_item(input logic [1:0] opcode, input logic [7:0] value);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = opcode;
      req_byte_value = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (opcode == OP_START)
         packets_open = 0;
      else if (opcode == OP_DECODE)
         packets_open++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pixels_pending != 0) @(negedge clock);
   endtask

   // Register writes only go out once the block has nothing left in flight.
   task automatic quiesce();
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [SPLIT_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One well-formed block: a start, a few bytes and one to three packets.
   task automatic run_block_sequence();
      int loads;
      int packets;
      loads = $urandom_range(0, 20);
      packets = $urandom_range(1, 3);
      send_item(OP_START, 8'($urandom));
      repeat (loads) send_item(OP_LOAD, 8'($urandom));
      repeat (packets) begin
         if ($urandom_range(0, 5) == 0) wait_drained();
         send_item(OP_DECODE, 8'($urandom));
      end
   endtask

   initial begin
      logic [SPLIT_W-1:0] split_value;
      int                 phase_start;
      logic [1:0]         stray_op;

      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_START;
      req_byte_value = 8'h00;
      csr_valid = 1'b0;
      csr_index = CSR_SPLIT;
      csr_wdata = '0;
      items_sent = 0;
      packets_open = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Write every byte that the first few packets after a start can reach, so
      // no decode ever reads an entry that was never written.
      write_reg(CSR_SPLIT, '0);
      write_reg(CSR_ZERO_BAD, '0);
      send_item(OP_START, 8'h00);
      repeat (FILL_BYTES) send_item(OP_LOAD, 8'($urandom));

      quiesce();
      write_reg(CSR_SPLIT, SPLIT_W'(DIRECTED_SPLIT));
      write_reg(CSR_ZERO_BAD, SPLIT_W'(1));
      idling_on = 1'b1;
      // Zero bytes under the first bits read give a zero first pixel.
      send_item(OP_START, 8'hff);
      send_item(OP_LOAD, 8'h00);
      send_item(OP_LOAD, 8'h00);
      send_item(OP_DECODE, 8'h00);
      send_item(OP_UNUSED, 8'hff);
      wait_drained();
      send_item(OP_DECODE, 8'hff);
      send_item(OP_START, 8'h00);
      send_item(OP_LOAD, 8'hff);
      send_item(OP_LOAD, 8'hff);
      send_item(OP_DECODE, 8'h00);
      // A start without loads decodes the same bytes again.
      send_item(OP_START, 8'h00);
      send_item(OP_DECODE, 8'h00);
      send_item(OP_UNUSED, 8'h00);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       split_value = '0;
            1:       split_value = SPLIT_W'(1);
            2:       split_value = SPLIT_W'(BLOCK_BYTES - 1);
            3:       split_value = SPLIT_W'(BLOCK_BYTES);
            4:       split_value = SPLIT_W'(SPLIT_MAX);
            5:       split_value = SPLIT_W'($urandom_range(2, BLOCK_BYTES - 2));
            6:       split_value = SPLIT_W'($urandom_range(BLOCK_BYTES + 1, SPLIT_MAX - 1));
            default: split_value = SPLIT_W'($urandom_range(0, SPLIT_MAX));
         endcase
         quiesce();
         write_reg(CSR_SPLIT, split_value);
         write_reg(CSR_ZERO_BAD, SPLIT_W'(ph % 2));
         idling_on = (ph != 2);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
               stray_op = 2'($urandom_range(0, 3));
               // A decode past the filled packets would read bytes never written.
               if (stray_op == OP_DECODE && packets_open >= FILL_PACKETS)
                  stray_op = OP_START;
               send_item(stray_op, 8'($urandom));
            end else
               run_block_sequence();
         end
      end

      // The last part runs with no idling on either side.
      quiesce();
      write_reg(CSR_ZERO_BAD, SPLIT_W'(1));
      idling_on = 1'b0;
      send_item(OP_START, 8'h00);
      repeat (FINAL_LOADS) send_item(OP_LOAD, 8'($urandom));
      repeat (FILL_PACKETS) send_item(OP_DECODE, 8'($urandom));

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pixels_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
